[hdl/csvp_pkg.sv]
package csvp_pkg;

  localparam logic [1:0] KIND_ROW    = 2'd0;
  localparam logic [1:0] KIND_COLUMN = 2'd1;
  localparam logic [1:0] KIND_TOTALS = 2'd2;

  localparam logic [1:0] REG_LINE_BREAK = 2'd0;
  localparam logic [1:0] REG_SEPARATOR  = 2'd1;
  localparam logic [1:0] REG_QUOTE      = 2'd2;
  localparam logic [1:0] REG_COLUMNS    = 2'd3;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] item_index;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
    logic [31:0] word_e;
    logic [31:0] word_f;
    logic        row_malformed;
    logic        is_last;
  } out_item_t;

  // one column table entry
  typedef struct packed {
    logic [31:0] min_len;
    logic [31:0] max_len;
    logic [31:0] empty_cnt;
    logic [31:0] string_cnt;
    logic [31:0] number_cnt;
    logic [31:0] float_cnt;
  } col_entry_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == ALL_ONES) ? v : v + 32'd1;
  endfunction

endpackage

[hdl/csv_column_profiler.sv]
// data bytes: one per cycle while the input is not stalled; a field close reads the column
//   table entry and writes it back in the WB state, during which the input is blocked
// row record leaves in the cycle after the line break byte, through the output register
// end item: writeback, then final row, then one descriptor per column, then totals, then
//   a clearing pass through the column table before input resumes
// reset: async, then the same clearing pass over all MAX_COLUMNS entries
module csv_column_profiler #(
  parameter int MAX_COLUMNS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  csvp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csvp_pkg::out_item_t out_data_o
);

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int FW = $clog2(MAX_COLUMNS + 2);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_WB    = 3'd2;
  localparam logic [2:0] ST_FROW  = 3'd3;
  localparam logic [2:0] ST_FRD   = 3'd4;
  localparam logic [2:0] ST_FCOL  = 3'd5;
  localparam logic [2:0] ST_FTOT  = 3'd6;

  logic [7:0] lb_q, sep_q, quo_q;
  logic [5:0] ccnt_q;

  logic [2:0] st_q, st_d;
  logic in_q_q, in_q_d, pend_q, pend_d, rogue_q, rogue_d, num_q, num_d;
  logic dot_q, dot_d, exp_q, exp_d, exps_q, exps_d;
  logic [7:0] prev_q, prev_d;
  logic [31:0] flen_q, flen_d, rlen_q, rlen_d, off_q, off_d;
  logic [31:0] rows_q, rows_d, bad_q, bad_d, short_q, short_d, long_q, long_d;
  logic [FW-1:0] fidx_q, fidx_d;
  logic [AW:0] cnt_q, cnt_d;

  // field close pending writeback
  logic wb_go_q, wb_go_d, wb_num_q, wb_num_d, wb_dot_q, wb_dot_d;
  logic [31:0] wb_len_q, wb_len_d;
  logic [AW-1:0] wb_adr_q, wb_adr_d;
  logic end_after_q, end_after_d;
  logic row_pend_q, row_pend_d;

  logic ov_q, ov_d;
  csvp_pkg::out_item_t od_q, od_d;

  csvp_pkg::col_entry_t mem [MAX_COLUMNS];
  csvp_pkg::col_entry_t rd_q;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  csvp_pkg::col_entry_t mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q <= 8'd10; sep_q <= 8'd44; quo_q <= 8'd34; ccnt_q <= 6'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        csvp_pkg::REG_LINE_BREAK: lb_q <= cfg_data_i;
        csvp_pkg::REG_SEPARATOR:  sep_q <= cfg_data_i;
        csvp_pkg::REG_QUOTE:      quo_q <= cfg_data_i;
        csvp_pkg::REG_COLUMNS: begin
          if (32'(cfg_data_i[5:0]) > 32'(MAX_COLUMNS)) ccnt_q <= 6'(MAX_COLUMNS);
          else ccnt_q <= cfg_data_i[5:0];
        end
        default: ;
      endcase
    end
  end

  logic out_free, in_acc;
  assign out_free = !ov_q || !out_stall_i;
  assign in_stall_o = !(st_q == ST_RUN && out_free && !wb_go_q);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  logic [5:0] fidx_ext;
  logic [31:0] len_now;
  logic num_now, dot_now, rec_ok, bad_row;
  logic [7:0] b;

  always_comb begin
    st_d = st_q; in_q_d = in_q_q; pend_d = pend_q; rogue_d = rogue_q; num_d = num_q;
    dot_d = dot_q; exp_d = exp_q; exps_d = exps_q; prev_d = prev_q; flen_d = flen_q;
    rlen_d = rlen_q; off_d = off_q; rows_d = rows_q; bad_d = bad_q; short_d = short_q;
    long_d = long_q; fidx_d = fidx_q; cnt_d = cnt_q;
    wb_go_d = 1'b0; wb_num_d = wb_num_q; wb_dot_d = wb_dot_q; wb_len_d = wb_len_q;
    wb_adr_d = wb_adr_q; end_after_d = end_after_q; row_pend_d = row_pend_q;
    ov_d = ov_q && out_stall_i; od_d = od_q;
    mem_we = 1'b0; mem_wa = wb_adr_q; mem_ra = wb_adr_q; mem_wd = rd_q;
    b = in_data_i.data_byte;
    fidx_ext = 6'(fidx_q);
    len_now = flen_q; num_now = num_q; dot_now = dot_q;
    rec_ok = 1'b0; bad_row = 1'b0;

    unique case (st_q)
      ST_CLEAR: begin
        mem_we = 1'b1; mem_wa = cnt_q[AW-1:0];
        mem_wd = '{min_len: csvp_pkg::ALL_ONES, default: 32'd0};
        if (32'(cnt_q) == 32'(MAX_COLUMNS - 1)) begin
          st_d = ST_RUN; cnt_d = '0;
        end else cnt_d = cnt_q + 1'b1;
      end
      ST_RUN: begin
        if (in_acc) begin
          if (in_data_i.req_type) begin
            // resolve the pending qualifier, then the final row
            if (pend_q) begin
              pend_d = 1'b0;
              if (in_q_q) in_q_d = 1'b0; else rogue_d = 1'b1;
            end
            if (rlen_q != 32'd0) begin
              rec_ok = 1'b1;
              bad_row = in_q_d || (6'(fidx_q + 1'b1) != ccnt_q && fidx_q != FW'(MAX_COLUMNS + 1))
                        || (fidx_q == FW'(MAX_COLUMNS + 1) && ccnt_q != fidx_ext) || rogue_d;
              row_pend_d = 1'b1;
            end else row_pend_d = 1'b0;
            end_after_d = 1'b1;
            st_d = ST_WB;
          end else if (pend_q && b == quo_q) begin
            pend_d = 1'b0; rlen_d = csvp_pkg::sat_inc(rlen_q);
            flen_d = csvp_pkg::sat_inc(flen_q); num_d = 1'b0; prev_d = b;
          end else begin
            if (pend_q) begin
              pend_d = 1'b0;
              if (in_q_q) in_q_d = 1'b0; else rogue_d = 1'b1;
            end
            rlen_d = csvp_pkg::sat_inc(rlen_q);
            prev_d = b;
            if (b == quo_q) begin
              if (flen_q == 32'd0 && !in_q_d) in_q_d = 1'b1;
              else if (flen_q != 32'd0) pend_d = 1'b1;
              else rogue_d = 1'b1;
            end else if ((b == sep_q || b == lb_q) && !in_q_d) begin
              rec_ok = 1'b1;
              end_after_d = 1'b0;
              if (b != sep_q) begin
                // row end: index after close, or a misplaced quote, decides malformed
                bad_row = (((fidx_q == FW'(MAX_COLUMNS + 1)) ? fidx_ext : 6'(fidx_q + 1'b1))
                           != ccnt_q) || rogue_d;
                if (bad_row) bad_d = csvp_pkg::sat_inc(bad_q);
                if (rlen_d < short_q) short_d = rlen_d;
                if (rlen_d > long_q) long_d = rlen_d;
                ov_d = 1'b1;
                od_d = '{result_kind: csvp_pkg::KIND_ROW, item_index: rows_q,
                         word_a: off_q, word_b: rlen_d, row_malformed: bad_row,
                         is_last: 1'b1, default: '0};
                off_d = (off_q + rlen_d < off_q) ? csvp_pkg::ALL_ONES : off_q + rlen_d;
                rows_d = csvp_pkg::sat_inc(rows_q);
                rogue_d = 1'b0; in_q_d = 1'b0; rlen_d = 32'd0;
              end
            end else begin
              if (b >= csvp_pkg::CH_ZERO && b <= csvp_pkg::CH_NINE) ;
              else if (b == csvp_pkg::CH_DOT && !dot_q) dot_d = 1'b1;
              else if (flen_q != 0 && b == csvp_pkg::CH_E && !exp_q) exp_d = 1'b1;
              else if (flen_q == 0 && b == csvp_pkg::CH_MINUS) ;
              else if (flen_q != 0 && (b == csvp_pkg::CH_MINUS || b == csvp_pkg::CH_PLUS)
                       && prev_q == csvp_pkg::CH_E && !exps_q) exps_d = 1'b1;
              else if (b != csvp_pkg::CH_CR) num_d = 1'b0;
              flen_d = csvp_pkg::sat_inc(flen_q);
            end
          end
          if (rec_ok) begin
            // close the field: start the table read, write back next cycle
            wb_go_d = (32'(fidx_q) < 32'(ccnt_q)) && (32'(fidx_q) < 32'(MAX_COLUMNS));
            wb_adr_d = fidx_q[AW-1:0];
            mem_ra = fidx_q[AW-1:0];
            wb_len_d = len_now; wb_num_d = num_now; wb_dot_d = dot_now;
            if (in_data_i.req_type) begin
              if (bad_row) bad_d = csvp_pkg::sat_inc(bad_q);
              od_d = '{result_kind: csvp_pkg::KIND_ROW, item_index: rows_q,
                       word_a: off_q, word_b: rlen_q, row_malformed: bad_row,
                       default: '0};
              rows_d = csvp_pkg::sat_inc(rows_q);
            end
            if (b == lb_q && !in_data_i.req_type && b != sep_q) fidx_d = '0;
            else if (fidx_q != FW'(MAX_COLUMNS + 1)) fidx_d = fidx_q + 1'b1;
            flen_d = 32'd0; num_d = 1'b1; dot_d = 1'b0; exp_d = 1'b0; exps_d = 1'b0;
          end
        end
      end
      ST_WB: begin
        // write back the closed field; rd_q holds the entry
        if (wb_go_q) begin
          mem_we = 1'b1;
          mem_wd = rd_q;
          if (wb_len_q != 32'd0) begin
            if (wb_len_q < rd_q.min_len) mem_wd.min_len = wb_len_q;
            if (wb_len_q > rd_q.max_len) mem_wd.max_len = wb_len_q;
            if (wb_num_q) begin
              mem_wd.number_cnt = csvp_pkg::sat_inc(rd_q.number_cnt);
              if (wb_dot_q) mem_wd.float_cnt = csvp_pkg::sat_inc(rd_q.float_cnt);
            end else mem_wd.string_cnt = csvp_pkg::sat_inc(rd_q.string_cnt);
          end else mem_wd.empty_cnt = csvp_pkg::sat_inc(rd_q.empty_cnt);
        end
        if (end_after_q) st_d = ST_FROW;
        else st_d = ST_RUN;
      end
      ST_FROW: begin
        if (out_free) begin
          if (row_pend_q) begin
            ov_d = 1'b1; row_pend_d = 1'b0;
          end
          cnt_d = '0;
          st_d = (ccnt_q == 6'd0) ? ST_FTOT : ST_FRD;
        end
      end
      ST_FRD: begin
        mem_ra = cnt_q[AW-1:0];
        st_d = ST_FCOL;
      end
      ST_FCOL: begin
        mem_ra = cnt_q[AW-1:0];
        if (out_free) begin
          ov_d = 1'b1;
          od_d = '{result_kind: csvp_pkg::KIND_COLUMN, item_index: 32'(cnt_q),
                   word_a: rd_q.min_len, word_b: rd_q.max_len, word_c: rd_q.empty_cnt,
                   word_d: rd_q.string_cnt, word_e: rd_q.number_cnt,
                   word_f: rd_q.float_cnt, default: '0};
          cnt_d = cnt_q + 1'b1;
          st_d = (6'(cnt_q) + 6'd1 == ccnt_q) ? ST_FTOT : ST_FRD;
        end
      end
      ST_FTOT: begin
        if (out_free) begin
          ov_d = 1'b1;
          od_d = '{result_kind: csvp_pkg::KIND_TOTALS, word_a: rows_q, word_b: bad_q,
                   word_c: short_q, word_d: long_q, is_last: 1'b1, default: '0};
          in_q_d = 1'b0; pend_d = 1'b0; rogue_d = 1'b0; num_d = 1'b1; dot_d = 1'b0;
          exp_d = 1'b0; exps_d = 1'b0; prev_d = '0; flen_d = '0; rlen_d = '0;
          fidx_d = '0; off_d = '0; rows_d = '0; bad_d = '0;
          short_d = csvp_pkg::ALL_ONES; long_d = '0; cnt_d = '0;
          st_d = ST_CLEAR;
        end
      end
      default: st_d = ST_CLEAR;
    endcase
    // a data byte that closes a field stalls the input for the writeback state
    if (st_q == ST_RUN && in_acc && rec_ok && !in_data_i.req_type) begin
      st_d = ST_WB; end_after_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; cnt_q <= '0; ov_q <= 1'b0; wb_go_q <= 1'b0;
      in_q_q <= 1'b0; pend_q <= 1'b0; rogue_q <= 1'b0; num_q <= 1'b1;
      dot_q <= 1'b0; exp_q <= 1'b0; exps_q <= 1'b0; prev_q <= '0;
      flen_q <= '0; rlen_q <= '0; off_q <= '0; rows_q <= '0; bad_q <= '0;
      short_q <= csvp_pkg::ALL_ONES; long_q <= '0; fidx_q <= '0;
      end_after_q <= 1'b0; row_pend_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ov_q <= ov_d; wb_go_q <= wb_go_d;
      in_q_q <= in_q_d; pend_q <= pend_d; rogue_q <= rogue_d; num_q <= num_d;
      dot_q <= dot_d; exp_q <= exp_d; exps_q <= exps_d; prev_q <= prev_d;
      flen_q <= flen_d; rlen_q <= rlen_d; off_q <= off_d; rows_q <= rows_d;
      bad_q <= bad_d; short_q <= short_d; long_q <= long_d; fidx_q <= fidx_d;
      end_after_q <= end_after_d; row_pend_q <= row_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d; wb_len_q <= wb_len_d; wb_num_q <= wb_num_d;
    wb_dot_q <= wb_dot_d; wb_adr_q <= wb_adr_d;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed under stall");
  a_wb_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_go_q |-> in_stall_o)
    else $error("input taken during table writeback");
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CLEAR |-> in_stall_o && mem_we)
    else $error("clear pass not exclusive");
  a_fidx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fidx_q) <= 32'(MAX_COLUMNS + 1))
    else $error("field index past saturation");

endmodule
